// ===== sv/spq_pkg.sv =====
// Shared constants, codes and types of the sorted insert priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 4;
   localparam int TAG_W    = 2;
   localparam int OCC_W    = 5;
   localparam int STAT_W   = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell in the chain.
   typedef struct packed {
      logic             insert;
      logic             pop;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cmd_type;

   // What one cell hands to the next cell down the chain.
   typedef struct packed {
      logic             ge;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } link_type;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts it up or down.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                      clock,
   input  spq_pkg::cmd_type          cmd,
   input  spq_pkg::link_type         prev,
   input  logic                      occupied,
   input  logic [spq_pkg::KEY_W-1:0] next_key,
   input  logic [spq_pkg::TAG_W-1:0] next_tag,
   output spq_pkg::link_type         link
);

   logic [spq_pkg::KEY_W-1:0] key_ff, key_in;
   logic [spq_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                      ge;

   // An entry with a greater or equal key stays ahead of the newcomer.
   assign ge = occupied && (key_ff >= cmd.key);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (cmd.insert && !ge) begin
         // The first cell that gives way takes the new entry; those behind it
         // take their upper neighbour's entry.
         key_in = prev.ge ? cmd.key : prev.key;
         tag_in = prev.ge ? cmd.tag : prev.tag;
      end else if (cmd.pop) begin
         key_in = next_key;
         tag_in = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign link.ge  = ge;
   assign link.key = key_ff;
   assign link.tag = tag_ff;

endmodule

// ===== sv/sorted_insert_priority_queue.sv =====
// Top level of the sorted insert priority queue: cell chain, count and result register.
`timescale 1ns / 1ps

// A bounded priority queue of spq_pkg::CAPACITY entries kept sorted by key,
// highest key at the head, in a chain of cells that all compare the incoming
// key at once. Each request word (insert or pop) yields exactly one result
// word. The block takes one request every clock cycle and answers it through
// a result register; the only stall comes from rsp_tready being low while a
// result is held. Equal keys leave in arrival order, an insert into a full
// queue is dropped with status 1 and a pop from an empty queue returns
// status 2. Occupancy is the entry count after the request, modulo 32.
module sorted_insert_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation [0], key [4:1], tag [6:5], zero [7]
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pop_valid [0], popped_key [4:1], popped_tag [6:5], status [8:7],
   // occupancy [13:9], zero [15:14]
   output logic [15:0] rsp_tdata
);

   localparam int N = spq_pkg::CAPACITY;

   logic                          req_acc;
   spq_pkg::op_type               op;
   logic [spq_pkg::KEY_W-1:0]     req_key;
   logic [spq_pkg::TAG_W-1:0]     req_tag;
   logic [spq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          full, empty;
   spq_pkg::cmd_type              cmd;
   spq_pkg::link_type             links [N];
   logic [N-1:0]                  occ;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pop_valid_ff, pop_valid_in;
   logic [spq_pkg::KEY_W-1:0]     pkey_ff, pkey_in;
   logic [spq_pkg::TAG_W-1:0]     ptag_ff, ptag_in;
   spq_pkg::status_type           status_ff, status_in;
   logic [spq_pkg::OCC_W-1:0]     occ_ff, occ_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign op         = spq_pkg::op_type'(req_tdata[0]);
   assign req_key    = req_tdata[4:1];
   assign req_tag    = req_tdata[6:5];

   assign full  = (count_ff == spq_pkg::CNT_W'(N));
   assign empty = (count_ff == '0);

   assign cmd.insert = req_acc && (op == spq_pkg::OP_INSERT) && !full;
   assign cmd.pop    = req_acc && (op == spq_pkg::OP_POP) && !empty;
   assign cmd.key    = req_key;
   assign cmd.tag    = req_tag;

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         spq_pkg::link_type prev_link;
         logic [spq_pkg::KEY_W-1:0] nkey;
         logic [spq_pkg::TAG_W-1:0] ntag;

         assign occ[i] = (count_ff > spq_pkg::CNT_W'(i));

         if (i == 0) begin : g_head
            assign prev_link.ge  = 1'b0;
            assign prev_link.key = req_key;
            assign prev_link.tag = req_tag;
         end else begin : g_body
            assign prev_link = links[i-1];
         end

         if (i == N - 1) begin : g_tail
            assign nkey = links[i].key;
            assign ntag = links[i].tag;
         end else begin : g_inner
            assign nkey = links[i+1].key;
            assign ntag = links[i+1].tag;
         end

         spq_cell u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .prev     (prev_link),
            .occupied (occ[i]),
            .next_key (nkey),
            .next_tag (ntag),
            .link     (links[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      pop_valid_in = pop_valid_ff;
      pkey_in      = pkey_ff;
      ptag_in      = ptag_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc) begin
         rsp_valid_in = 1'b1;
         pop_valid_in = 1'b0;
         pkey_in      = '0;
         ptag_in      = '0;
         status_in    = spq_pkg::ST_OK;
         if (cmd.insert) begin
            count_in = count_ff + 1'b1;
         end else if (cmd.pop) begin
            count_in     = count_ff - 1'b1;
            pop_valid_in = 1'b1;
            pkey_in      = links[0].key;
            ptag_in      = links[0].tag;
         end else if (op == spq_pkg::OP_INSERT) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            status_in = spq_pkg::ST_EMPTY;
         end
         occ_in = spq_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pop_valid_ff <= pop_valid_in;
      pkey_ff      <= pkey_in;
      ptag_ff      <= ptag_in;
      status_ff    <= status_in;
      occ_ff       <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, occ_ff, status_ff, ptag_ff, pkey_ff, pop_valid_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_W'(N))
      else $error("entry count beyond capacity");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not lower the entry count");

   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> occ_ff == spq_pkg::OCC_W'(count_ff))
      else $error("reported occupancy differs from the entry count");

   a_pop_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> pop_valid_ff && rsp_valid_ff && (status_ff == spq_pkg::ST_OK))
      else $error("pop word not delivered with its flag");

endmodule
